// ===== design/xpra_pkg.sv =====
`timescale 1ns / 1ps

package xpra_pkg;

    localparam int WORD_W   = 64;
    localparam int FILE_W   = 16;
    localparam int WIDX_W   = 10;
    localparam int QBYTES_W = 64;
    localparam int QID_W    = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int ACTQ_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_QUERIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_ORDER      = 2'd1;

    localparam logic [ACTQ_W-1:0] ACTQ_RESET = 4'd8;
    localparam logic [2:0]        BIT_TOP    = 3'd7;

    // per-cell control for the item in the accumulate stage
    typedef struct packed {
        logic en;       // cell serves this item
        logic sel;      // query selects this file
        logic last;     // final reply beat of the pass
        logic finish;   // last-file word: emit and clear
    } cell_ctl_t;

    // output chain control, shared by all cells
    typedef struct packed {
        logic load;
        logic shift;
    } bank_ctl_t;

    typedef struct packed {
        logic [QID_W-1:0]  query_id;
        logic              last;
        logic [WORD_W-1:0] word;
    } beat_t;

endpackage

// ===== design/xpra_if.sv =====
`timescale 1ns / 1ps

interface xpra_in_if;
    logic                          valid;
    logic                          ready;
    logic [xpra_pkg::WORD_W-1:0]   db_word;
    logic [xpra_pkg::FILE_W-1:0]   file_index;
    logic [xpra_pkg::WIDX_W-1:0]   word_index;
    logic [xpra_pkg::QBYTES_W-1:0] query_bytes;
    logic                          last_file;

    modport source (output valid, db_word, file_index, word_index, query_bytes, last_file,
                    input ready);
    modport sink   (input valid, db_word, file_index, word_index, query_bytes, last_file,
                    output ready);
endinterface

interface xpra_out_if;
    logic                        valid;
    logic                        ready;
    logic [xpra_pkg::QID_W-1:0]  query_id;
    logic [xpra_pkg::WIDX_W-1:0] reply_index;
    logic [xpra_pkg::WORD_W-1:0] reply_word;
    logic                        last;

    modport source (output valid, query_id, reply_index, reply_word, last, input ready);
    modport sink   (input valid, query_id, reply_index, reply_word, last, output ready);
endinterface

// ===== design/xpra_cell.sv =====
`timescale 1ns / 1ps

module xpra_cell #(
    parameter int MAX_WORDS = 1024,
    parameter int AW        = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  xpra_pkg::bank_ctl_t         bank,
    input  xpra_pkg::cell_ctl_t         ctl,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    input  logic [AW-1:0]               wr_addr,
    input  logic                        clr,
    input  logic [xpra_pkg::WORD_W-1:0] word,
    input  logic [xpra_pkg::QID_W-1:0]  query_id,
    input  xpra_pkg::beat_t             nbr_beat,
    input  logic                        nbr_valid,
    output xpra_pkg::beat_t             beat,
    output logic                        beat_valid
);

    logic [xpra_pkg::WORD_W-1:0] mem [MAX_WORDS];
    logic [xpra_pkg::WORD_W-1:0] rd_reg;
    logic [xpra_pkg::WORD_W-1:0] lw_data_reg;
    logic [AW-1:0]               lw_addr_reg;
    logic                        lw_valid_reg;
    xpra_pkg::beat_t             beat_reg;
    logic                        beat_valid_reg;

    logic [xpra_pkg::WORD_W-1:0] cur;
    logic [xpra_pkg::WORD_W-1:0] acc;
    logic [xpra_pkg::WORD_W-1:0] wdata;
    logic                        we;

    always_comb
    begin
        // the read was issued before the previous beat's write landed
        if (lw_valid_reg && (lw_addr_reg == wr_addr))
        begin
            cur = lw_data_reg;
        end
        else
        begin
            cur = rd_reg;
        end
        acc   = cur ^ (ctl.sel ? word : '0);
        we    = clr | ctl.en;
        wdata = (clr | ctl.finish) ? '0 : acc;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (we)
        begin
            mem[wr_addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wdata;
        if (bank.load)
        begin
            beat_reg <= '{query_id: query_id, last: ctl.last, word: acc};
        end
        else if (bank.shift)
        begin
            beat_reg <= nbr_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg   <= 1'b0;
            beat_valid_reg <= 1'b0;
        end
        else
        begin
            lw_valid_reg <= we;
            if (bank.load)
            begin
                beat_valid_reg <= ctl.en & ctl.finish;
            end
            else if (bank.shift)
            begin
                beat_valid_reg <= nbr_valid;
            end
        end
    end

    assign beat       = beat_reg;
    assign beat_valid = beat_valid_reg;

endmodule

// ===== design/xor_pir_reply_accumulator_top.sv =====
`timescale 1ns / 1ps

// XOR PIR reply accumulator: one database word per beat is XORed into the
// reply accumulators of every active query whose selection bit for the file
// is set. Each query is one cell of a row holding its own MAX_WORDS x 64 RAM;
// an item is read in the accept cycle and written back in the next cycle,
// with a bypass for back-to-back hits on one word. Words that are not from
// the last file are taken one per cycle while the output chain is empty. A
// last-file word loads each active cell's finished reply into an output
// chain that shifts toward cell 0, one beat per cycle while the receiver is
// ready; input is held until that chain is empty. After reset a clearing
// pass zeroes the RAMs, during which no item is accepted (configuration
// writes are taken as ever).
module xor_pir_reply_accumulator_top #(
    parameter int MAX_QUERIES = 8,
    parameter int MAX_WORDS   = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    xpra_in_if.sink                         in_ch,
    xpra_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [xpra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [xpra_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CMPW = 17;

    logic [xpra_pkg::ACTQ_W-1:0] actq_reg;
    logic                        bit_order_reg;

    logic                        clearing_reg;
    logic [AW-1:0]               clr_addr_reg;

    logic                        s1_valid_reg;
    logic [xpra_pkg::WORD_W-1:0] s1_word_reg;
    logic [AW-1:0]               s1_addr_reg;
    logic [xpra_pkg::WIDX_W-1:0] s1_widx_reg;
    logic                        s1_finish_reg;
    logic                        s1_last_reg;
    logic [MAX_QUERIES-1:0]      s1_sel_reg;

    logic [xpra_pkg::WIDX_W-1:0] bank_index_reg;

    logic [xpra_pkg::ACTQ_W-1:0] nq;
    logic                        accept;
    logic                        in_range;
    logic [2:0]                  bit_pos;
    logic [AW-1:0]               in_addr;
    logic [AW-1:0]               wr_addr;
    logic                        bank_empty;
    xpra_pkg::bank_ctl_t         bank;

    xpra_pkg::beat_t             chain_beat  [MAX_QUERIES+1];
    logic                        chain_valid [MAX_QUERIES+1];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            actq_reg      <= xpra_pkg::ACTQ_RESET;
            bit_order_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                xpra_pkg::CFG_ACTIVE_QUERIES: actq_reg      <= cfg_data;
                xpra_pkg::CFG_BIT_ORDER:      bit_order_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign nq = (actq_reg > xpra_pkg::ACTQ_W'(MAX_QUERIES)) ?
                xpra_pkg::ACTQ_W'(MAX_QUERIES) : actq_reg;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(MAX_WORDS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign bank_empty  = !chain_valid[0];
    // hold input while a last-file word waits to load the chain
    assign in_ch.ready = !clearing_reg && bank_empty && !(s1_valid_reg && s1_finish_reg);
    assign accept      = in_ch.valid && in_ch.ready;

    assign in_range = CMPW'(in_ch.word_index) < CMPW'(MAX_WORDS);
    assign bit_pos  = bit_order_reg ? (xpra_pkg::BIT_TOP - in_ch.file_index[2:0])
                                    : in_ch.file_index[2:0];
    assign in_addr  = AW'(in_ch.word_index);
    assign wr_addr  = clearing_reg ? clr_addr_reg : s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg   <= in_ch.db_word;
            s1_addr_reg   <= in_addr;
            s1_widx_reg   <= in_ch.word_index;
            s1_finish_reg <= in_ch.last_file;
            s1_last_reg   <= CMPW'(in_ch.word_index) == CMPW'(MAX_WORDS - 1);
            for (int q = 0; q < MAX_QUERIES; q++)
            begin
                s1_sel_reg[q] <= in_ch.query_bytes[8*q + int'(bit_pos)];
            end
        end
        if (bank.load)
        begin
            bank_index_reg <= s1_widx_reg;
        end
    end

    assign bank.load  = s1_valid_reg && s1_finish_reg;
    assign bank.shift = out_ch.valid && out_ch.ready;

    assign chain_beat[MAX_QUERIES]  = '0;
    assign chain_valid[MAX_QUERIES] = 1'b0;

    for (genvar q = 0; q < MAX_QUERIES; q++)
    begin : g_cell
        xpra_pkg::cell_ctl_t ctl;

        assign ctl.en     = s1_valid_reg && (xpra_pkg::ACTQ_W'(q) < nq);
        assign ctl.sel    = s1_sel_reg[q];
        assign ctl.last   = s1_last_reg && (xpra_pkg::ACTQ_W'(q + 1) == nq);
        assign ctl.finish = s1_finish_reg;

        xpra_cell #(
            .MAX_WORDS (MAX_WORDS),
            .AW        (AW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .bank       (bank),
            .ctl        (ctl),
            .rd_en      (accept),
            .rd_addr    (in_addr),
            .wr_addr    (wr_addr),
            .clr        (clearing_reg),
            .word       (s1_word_reg),
            .query_id   (xpra_pkg::QID_W'(q)),
            .nbr_beat   (chain_beat[q+1]),
            .nbr_valid  (chain_valid[q+1]),
            .beat       (chain_beat[q]),
            .beat_valid (chain_valid[q])
        );
    end

    assign out_ch.valid       = chain_valid[0];
    assign out_ch.query_id    = chain_beat[0].query_id;
    assign out_ch.reply_index = bank_index_reg;
    assign out_ch.reply_word  = chain_beat[0].word;
    assign out_ch.last        = chain_beat[0].last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_Q       = 8;
    localparam int MAX_WORDS   = 1024;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 45;
    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 400000;

    // indexes with no register behind them
    localparam logic [xpra_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [xpra_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [xpra_pkg::WORD_W-1:0]   db_word;
        logic [xpra_pkg::FILE_W-1:0]   file_index;
        logic [xpra_pkg::WIDX_W-1:0]   word_index;
        logic [xpra_pkg::QBYTES_W-1:0] query_bytes;
        logic                          last_file;
    } db_beat_t;

    typedef struct packed {
        logic [xpra_pkg::QID_W-1:0]  query_id;
        logic [xpra_pkg::WIDX_W-1:0] reply_index;
        logic [xpra_pkg::WORD_W-1:0] reply_word;
        logic                        last;
    } reply_t;

    // Running XOR sums per query and word position, plus the replies they owe.
    class reply_ledger;
        bit   [xpra_pkg::WORD_W-1:0] sums [MAX_Q][MAX_WORDS];
        logic [xpra_pkg::ACTQ_W-1:0] act_queries = xpra_pkg::ACTQ_RESET;
        logic                        msb_first   = 1'b0;
        reply_t                      due [$];
        int                          mismatches  = 0;
        int                          replies_ok  = 0;

        function void configure(logic [xpra_pkg::CFG_IDX_W-1:0] idx,
                                logic [xpra_pkg::CFG_DATA_W-1:0] val);
            if (idx == xpra_pkg::CFG_ACTIVE_QUERIES)
                act_queries = val;
            else if (idx == xpra_pkg::CFG_BIT_ORDER)
                msb_first = val[0];
        endfunction

        function void absorb_word(db_beat_t b);
            int         served;
            logic [2:0] bit_pos;
            logic [7:0] sel_byte;
            reply_t     r;
            served  = (act_queries > MAX_Q) ? MAX_Q : int'(act_queries);
            bit_pos = msb_first ? xpra_pkg::BIT_TOP - b.file_index[2:0] : b.file_index[2:0];
            for (int q = 0; q < served; q++)
            begin
                sel_byte = b.query_bytes[8*q +: 8];
                if (sel_byte[bit_pos])
                    sums[q][b.word_index] ^= b.db_word;
            end
            if (b.last_file)
            begin
                for (int q = 0; q < served; q++)
                begin
                    r.query_id    = q[xpra_pkg::QID_W-1:0];
                    r.reply_index = b.word_index;
                    r.reply_word  = sums[q][b.word_index];
                    r.last        = (q == served - 1) && (b.word_index == MAX_WORDS - 1);
                    sums[q][b.word_index] = '0;
                    due.push_back(r);
                end
            end
        endfunction

        function bit field_ok(string what, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
                mismatches++;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void match_reply(reply_t got);
            reply_t want;
            bit     ok;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected reply beat: expected none, %s q=%0d idx=%0d word=%h last=%0b",
                         $time, "got", got.query_id, got.reply_index, got.reply_word,
                         got.last);
                mismatches++;
                return;
            end
            want = due.pop_front();
            ok   = field_ok("query_id", want.query_id, got.query_id);
            ok  &= field_ok("reply_index", want.reply_index, got.reply_index);
            ok  &= field_ok("reply_word", want.reply_word, got.reply_word);
            ok  &= field_ok("last", want.last, got.last);
            if (ok)
                replies_ok++;
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [xpra_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [xpra_pkg::CFG_DATA_W-1:0] cfg_data;

    xpra_in_if  in_ch ();
    xpra_out_if out_ch ();

    xor_pir_reply_accumulator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    reply_ledger ledger;
    int          words_sent  = 0;
    int          burst_left  = 0;
    int          cycles      = 0;
    int          stall_left  = 0;
    int          ready_ctr   = 0;
    int          settings    = 1;

    logic [xpra_pkg::ACTQ_W-1:0] phase_actq  [PHASES] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3,
                                                          4'd9, 4'd8};
    logic                        phase_order [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                                                          1'b0, 1'b1};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check replies before noting the word of this edge; a reply never
    // belongs to a word accepted at the same edge.
    always @(posedge clk)
    begin : watch
        reply_t   seen;
        db_beat_t took;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen.query_id    = out_ch.query_id;
                seen.reply_index = out_ch.reply_index;
                seen.reply_word  = out_ch.reply_word;
                seen.last        = out_ch.last;
                ledger.match_reply(seen);
            end
            if (in_ch.valid && in_ch.ready)
            begin
                took.db_word     = in_ch.db_word;
                took.file_index  = in_ch.file_index;
                took.word_index  = in_ch.word_index;
                took.query_bytes = in_ch.query_bytes;
                took.last_file   = in_ch.last_file;
                ledger.absorb_word(took);
            end
        end
    end

    // Receiver: rotate through always-ready, random, periodic and long-stall modes.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            ready_ctr++;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (ready_ctr[8:7])
                    2'd0: out_ch.ready <= 1'b1;
                    2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2'd2: out_ch.ready <= (ready_ctr % 3 != 0);
                    default:
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            stall_left = $urandom_range(1, 11);
                            out_ch.ready <= 1'b0;
                        end
                        else
                            out_ch.ready <= 1'b1;
                    end
                endcase
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input logic [xpra_pkg::WORD_W-1:0]   word,
                             input logic [xpra_pkg::FILE_W-1:0]   file,
                             input logic [xpra_pkg::WIDX_W-1:0]   widx,
                             input logic [xpra_pkg::QBYTES_W-1:0] qbytes,
                             input logic                          fin);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.db_word     <= word;
        in_ch.file_index  <= file;
        in_ch.word_index  <= widx;
        in_ch.query_bytes <= qbytes;
        in_ch.last_file   <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Hold the input until every owed reply is out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (ledger.pending() != 0);
    endtask

    task automatic cfg_write(input logic [xpra_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [xpra_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        ledger.configure(idx, val);
    endtask

    // Mostly whole passes over a small window of word positions: a few
    // rounds of plain files, then one final-file round that collects them.
    task automatic random_step();
        int base;
        int span;
        int rounds;
        span = $urandom_range(1, 4);
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 3))
                0:       base = 0;
                1:       base = MAX_WORDS - span;
                default: base = $urandom_range(0, MAX_WORDS - span);
            endcase
            rounds = $urandom_range(1, 5);
            for (int r = 0; r < rounds; r++)
                for (int k = 0; k < span; k++)
                    send_beat(rand64(), xpra_pkg::FILE_W'($urandom_range(0, 65535)),
                              xpra_pkg::WIDX_W'(base + $urandom_range(0, span - 1)),
                              rand64(), 1'b0);
            for (int k = 0; k < span; k++)
                send_beat(rand64(), xpra_pkg::FILE_W'($urandom_range(0, 65535)),
                          xpra_pkg::WIDX_W'(base + k), rand64(), 1'b1);
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        else
            send_beat(rand64(), xpra_pkg::FILE_W'($urandom_range(0, 65535)),
                      xpra_pkg::WIDX_W'($urandom_range(0, MAX_WORDS - 1)),
                      rand64(), $urandom_range(0, 3) == 0);
    endtask

    task automatic directed();
        // all queries select file 0, then file 7 via the top bit
        send_beat('1, 16'h0000, 10'd0, '1, 1'b0);
        send_beat(64'h0123_4567_89ab_cdef, 16'hffff, 10'd0, {8{8'h80}}, 1'b0);
        send_beat(64'hdead_beef_0000_0001, 16'h0001, 10'd0, '0, 1'b1);
        // top word position: only query 2 selects file 2, final beat carries last
        send_beat({16{4'ha}}, 16'h8002, 10'd1023, 64'h8040_2010_0804_0201, 1'b0);
        send_beat({16{4'h5}}, 16'h7ffa, 10'd1023, '1, 1'b1);
        // back-to-back hits on one word
        send_beat(64'h1111_1111_1111_1111, 16'h0004, 10'd5, '1, 1'b0);
        send_beat(64'h2222_2222_2222_2222, 16'h0005, 10'd5, {8{8'h20}}, 1'b0);
        send_beat(64'h4444_4444_4444_4444, 16'h0006, 10'd5, {8{8'h40}}, 1'b0);
        send_beat(64'h8888_8888_8888_8888, 16'h0007, 10'd5, '0, 1'b1);
        // final-file word that is itself selected
        send_beat(64'hfedc_ba98_7654_3210, 16'h0003, 10'd512, {8{8'h08}}, 1'b1);
        // nothing accumulated: replies of zero
        send_beat('0, 16'h0000, 10'd341, '0, 1'b1);
        send_beat(64'hffff_0000_ffff_0000, 16'haaaa, 10'd682, 64'h00ff_00ff_00ff_00ff, 1'b0);
        send_beat(64'h0000_ffff_0000_ffff, 16'h5555, 10'd682, 64'hff00_ff00_ff00_ff00, 1'b1);
    endtask

    initial
    begin : stimulus
        int start;
        ledger            = new();
        rst_n             = 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.db_word     <= '0;
        in_ch.file_index  <= '0;
        in_ch.word_index  <= '0;
        in_ch.query_bytes <= '0;
        in_ch.last_file   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                // a zero-query phase owes nothing; let the pipe settle anyway
                repeat (SETTLE) @(posedge clk);
                cfg_write(xpra_pkg::CFG_ACTIVE_QUERIES, phase_actq[p]);
                cfg_write(xpra_pkg::CFG_BIT_ORDER, {3'($urandom_range(0, 7)), phase_order[p]});
                cfg_write(CFG_SPARE_LO, xpra_pkg::CFG_DATA_W'($urandom_range(0, 15)));
                cfg_write(CFG_SPARE_HI, xpra_pkg::CFG_DATA_W'($urandom_range(0, 15)));
                cfg_we <= 1'b0;
                settings++;
            end
            start = words_sent;
            while (words_sent - start < PHASE_ITEMS)
                random_step();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Streamed %0d database words under %0d query-count/bit-order settings",
                 words_sent, settings);
        $display("(zero and saturated query counts included); %0d reply words matched",
                 ledger.replies_ok);
        if (ledger.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== xor_pir_reply_accumulator_top.f =====
design/xpra_pkg.sv
design/xpra_if.sv
design/xpra_cell.sv
design/xor_pir_reply_accumulator_top.sv
tb/tb_top.sv
